// File: hw/rtl/tksi_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tksi_pkg
// Shared widths, codes and types for the top-K sorted insertion list.
// ---------------------------------------------------------------------------
package tksi_pkg;

    localparam int LIST_DEPTH_DEF = 10;
    localparam int TAG_W          = 16;
    localparam int SCORE_W        = 32;
    localparam int COUNT_W        = 5;
    localparam int RANK_W         = 4;

    localparam logic [TAG_W-1:0] UNKNOWN_TAG_RST = 16'd1;
    localparam logic [TAG_W-1:0] EMPTY_TAG       = 16'd0;

    // Operation carried by the mode field.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // One stored entry of the list.
    typedef struct packed {
        logic                      valid;
        logic [TAG_W-1:0]          tag;
        logic signed [SCORE_W-1:0] score;
    } t_entry;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic   taken;  // the new entry lands at or above this link
        t_entry entry;  // content of the cell on the left
    } t_link;

endpackage
`default_nettype wire

// File: hw/rtl/tksi_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tksi_cell
// One rank position: holds an entry, compares it against the new score and
// either keeps it, takes the new entry or takes its left neighbor's entry.
// ---------------------------------------------------------------------------
module tksi_cell
    import tksi_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_ins,
    input  wire logic [TAG_W-1:0]          i_new_tag,
    input  wire logic signed [SCORE_W-1:0] i_new_score,
    input  wire t_link                     i_prev,
    output t_link                          o_next,
    output logic                           o_first,
    output t_entry                         o_entry
);

    logic                      r_valid;
    logic [TAG_W-1:0]          r_tag;
    logic signed [SCORE_W-1:0] r_score;
    logic                      w_hit;

    // The new entry belongs here if it beats this entry or the cell is free.
    assign w_hit   = !r_valid || (i_new_score > r_score);
    assign o_first = w_hit && !i_prev.taken;

    assign o_next.taken       = i_prev.taken || w_hit;
    assign o_next.entry.valid = r_valid;
    assign o_next.entry.tag   = r_tag;
    assign o_next.entry.score = r_score;

    assign o_entry.valid = r_valid;
    assign o_entry.tag   = r_tag;
    assign o_entry.score = r_score;

    // Valid bit: shifts down behind an insertion, set where the entry lands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ins) begin
            if (i_prev.taken) begin
                r_valid <= i_prev.entry.valid;
            end else if (w_hit) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Entry payload follows the same choice.
    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            if (i_prev.taken) begin
                r_tag   <= i_prev.entry.tag;
                r_score <= i_prev.entry.score;
            end else if (w_hit) begin
                r_tag   <= i_new_tag;
                r_score <= i_new_score;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/top_k_sorted_insert_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_sorted_insert_core
// Bounded list of (tag, score) entries kept sorted by descending score.
// ---------------------------------------------------------------------------
// One beat is taken per clock cycle unless the output stalls; it returns its
// result from an output register; a new beat is taken while the previous
// result is still waiting, as long as that result is taken in the same cycle.
// Each rank position is a cell; an insert compares the new score against all
// cells at once and every cell below the landing point copies its upper
// neighbor in the same cycle. The ripple of the landing flag down the row of
// LIST_DEPTH cells sets the cycle time. Ties go after existing entries, a
// full list drops its last entry, and a new score that beats nothing in a
// full list is rejected with accepted = 0. A zero tag is stored as the
// configured unknown tag. Configuration writes are taken in any cycle.
// ---------------------------------------------------------------------------
module top_k_sorted_insert_core
    import tksi_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Configuration write channel.
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [TAG_W-1:0]          i_cfg_data,
    // Input channel.
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_mode,
    input  wire logic [TAG_W-1:0]          i_name_tag,
    input  wire logic signed [SCORE_W-1:0] i_score,
    input  wire logic [RANK_W-1:0]         i_read_index,
    // Output channel.
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_accepted,
    output logic [RANK_W-1:0]              o_rank,
    output logic [COUNT_W-1:0]             o_entry_count,
    output logic                           o_entry_valid,
    output logic [TAG_W-1:0]               o_entry_tag,
    output logic signed [SCORE_W-1:0]      o_entry_score
);

    logic [TAG_W-1:0]   r_unknown_tag;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;

    logic                      w_in_beat;
    logic                      w_ins;
    logic                      w_ins_ok;
    logic [TAG_W-1:0]          w_new_tag;
    logic [RANK_W-1:0]         w_rank;
    logic                      w_rd_valid;
    logic [TAG_W-1:0]          w_rd_tag;
    logic signed [SCORE_W-1:0] w_rd_score;

    t_link                  w_link  [LIST_DEPTH+1];
    t_entry                 w_entry [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]  w_first;
    logic [LIST_DEPTH-1:0]  w_valid_vec;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_beat   = i_in_valid && o_in_ready;
    assign w_ins       = w_in_beat && (i_mode == MODE_INSERT);
    assign w_new_tag   = (i_name_tag == EMPTY_TAG) ? r_unknown_tag : i_name_tag;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unknown_tag <= UNKNOWN_TAG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_unknown_tag <= i_cfg_data;
        end
    end

    // Row of cells; the top link never carries a landing flag.
    assign w_link[0] = '0;

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        tksi_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ins       (w_ins),
            .i_new_tag   (w_new_tag),
            .i_new_score (i_score),
            .i_prev      (w_link[g]),
            .o_next      (w_link[g+1]),
            .o_first     (w_first[g]),
            .o_entry     (w_entry[g])
        );
        assign w_valid_vec[g] = w_entry[g].valid;
    end

    // The insert lands if some cell takes it.
    assign w_ins_ok = w_link[LIST_DEPTH].taken;

    // Landing position from the one-hot first-hit vector.
    always_comb begin
        w_rank = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_first[i]) begin
                w_rank = w_rank | RANK_W'(i);
            end
        end
    end

    // Read selection over the cells.
    always_comb begin
        w_rd_valid = 1'b0;
        w_rd_tag   = '0;
        w_rd_score = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if ((RANK_W'(i) == i_read_index) && w_entry[i].valid) begin
                w_rd_valid = 1'b1;
                w_rd_tag   = w_entry[i].tag;
                w_rd_score = w_entry[i].score;
            end
        end
    end

    // Entry count grows until the list is full.
    always_comb begin
        n_count = r_count;
        if (w_ins && w_ins_ok && (r_count < COUNT_W'(LIST_DEPTH))) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            o_entry_count <= n_count;
            if (i_mode == MODE_INSERT) begin
                o_accepted    <= w_ins_ok;
                o_rank        <= w_ins_ok ? w_rank : '0;
                o_entry_valid <= 1'b0;
                o_entry_tag   <= '0;
                o_entry_score <= '0;
            end else begin
                o_accepted    <= 1'b0;
                o_rank        <= '0;
                o_entry_valid <= w_rd_valid;
                o_entry_tag   <= w_rd_tag;
                o_entry_score <= w_rd_score;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // The count never passes the list depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    // The cells' valid bits agree with the entry count.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_count))
        else $error("valid cells disagree with entry count");

    // At most one cell claims the landing position.
    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one landing cell");

    // An insert result never carries read data.
    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_accepted) |-> !o_entry_valid)
        else $error("insert and read results mixed");

endmodule
`default_nettype wire
